### rtl/core/bca_pkg.sv
`timescale 1ns / 1ps

package bca_pkg;

    localparam int CFG_W     = 13;
    localparam int OP_W      = 2;
    localparam int CLUSTER_W = 12;
    localparam int STATUS_W  = 2;
    localparam int TDATA_W   = 16;

    localparam int CFG_RESET = 4096;
    localparam int MIN_COUNT = 4;
    localparam int FIRST_FREE = 3;

    localparam int WORD_W = 8;
    localparam int BIT_W  = 3;
    localparam logic [WORD_W-1:0] FIRST_WORD = 8'hf8;
    localparam logic [WORD_W-1:0] FULL_WORD  = 8'hff;

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC   = 2'd0,
        OP_RELEASE = 2'd1,
        OP_FORMAT  = 2'd2,
        OP_NOP     = 2'd3
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        STS_OK     = 2'd0,
        STS_FULL   = 2'd1,
        STS_REJECT = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_DECODE,
        S_CLEAR,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_REL_RD,
        S_REL_WR,
        S_OUT
    } state_t;

    typedef struct packed {
        logic    item_load;
        logic    clear_start;
        logic    clear_write;
        logic    scan_read;
        logic    scan_next;
        logic    phase_b;
        logic    alloc_commit;
        logic    rel_read;
        logic    rel_write;
        logic    res_set;
        logic    res_alloc;
        status_t res_status;
        logic    out_load;
    } dp_cmd_t;

    typedef struct packed {
        opcode_t op;
        logic    rel_ok;
        logic    hit;
        logic    word_last;
        logic    in_phase_b;
        logic    b_empty;
        logic    clear_last;
        logic    out_free;
    } dp_stat_t;

endpackage

### rtl/core/bca_ram.sv
`timescale 1ns / 1ps

module bca_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/core/bca_datapath.sv
`timescale 1ns / 1ps

module bca_datapath #(
    parameter int MAX_CLUSTERS = 4096
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_valid,
    input  logic [bca_pkg::CFG_W-1:0]          cfg_data,
    input  logic [bca_pkg::TDATA_W-1:0]        s_tdata,
    input  logic [bca_pkg::OP_W-1:0]           s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [bca_pkg::TDATA_W-1:0]        m_tdata,
    output logic [bca_pkg::STATUS_W-1:0]       m_tuser,
    input  bca_pkg::dp_cmd_t                   cmd,
    output bca_pkg::dp_stat_t                  stat
);

    localparam int WW    = bca_pkg::WORD_W;
    localparam int BW    = bca_pkg::BIT_W;
    localparam int CLW   = bca_pkg::CLUSTER_W;
    localparam int CW    = $clog2(MAX_CLUSTERS);
    localparam int NW    = $clog2(MAX_CLUSTERS + 1);
    localparam int DEPTH = (MAX_CLUSTERS + WW - 1) / WW;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PW    = AW + BW;
    localparam int LW    = PW + 1;
    localparam int COUNT_RESET =
        (MAX_CLUSTERS < bca_pkg::CFG_RESET) ? MAX_CLUSTERS : bca_pkg::CFG_RESET;

    logic [NW-1:0]           count_reg;
    logic [CW-1:0]           ss_reg;
    logic                    fresh_reg;
    logic [AW-1:0]           word_reg;
    logic                    phase_b_reg;
    bca_pkg::opcode_t        op_reg;
    logic [CLW-1:0]          cin_reg;
    logic [NW-1:0]           lo_reg;
    logic [NW-1:0]           hi_reg;
    logic [NW-1:0]           start_reg;
    logic [CLW-1:0]          res_cluster_reg;
    bca_pkg::status_t        res_status_reg;
    logic                    out_valid_reg;
    logic [CLW-1:0]          out_cluster_reg;
    logic [bca_pkg::STATUS_W-1:0] out_status_reg;
    logic                    out_formatted_reg;

    logic [NW-1:0]           count_cfg;
    logic [NW-1:0]           start_pos;
    logic [LW-1:0]           bit_pos;
    logic [WW-1:0]           cand;
    logic                    hit;
    logic [BW-1:0]           hit_idx;
    logic [PW-1:0]           hit_pos;
    logic [LW-1:0]           pos1;
    logic [CW-1:0]           ss_next;
    logic                    rel_ok;
    logic [AW-1:0]           cin_word;
    logic [AW-1:0]           end_word;
    logic                    out_free;

    logic                    ram_we;
    logic [AW-1:0]           ram_waddr;
    logic [WW-1:0]           ram_wdata;
    logic                    ram_re;
    logic [AW-1:0]           ram_raddr;
    logic [WW-1:0]           ram_rdata;

    bca_ram #(
        .WIDTH (WW),
        .DEPTH (DEPTH)
    ) u_map (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb begin
        if (32'(cfg_data) > 32'(MAX_CLUSTERS)) begin
            count_cfg = NW'(MAX_CLUSTERS);
        end else if (32'(cfg_data) < 32'(bca_pkg::MIN_COUNT)) begin
            count_cfg = NW'(bca_pkg::MIN_COUNT);
        end else begin
            count_cfg = NW'(cfg_data);
        end
    end

    assign start_pos = (LW'(ss_reg) < LW'(count_reg)) ? NW'(ss_reg) : '0;

    always_comb begin
        cand    = '0;
        bit_pos = '0;
        for (int b = 0; b < WW; b++) begin
            bit_pos = LW'({word_reg, BW'(b)});
            cand[b] = ram_rdata[b] && (bit_pos >= LW'(lo_reg)) && (bit_pos < LW'(hi_reg));
        end
    end

    always_comb begin
        hit_idx = '0;
        for (int b = WW - 1; b >= 0; b--) begin
            if (cand[b]) begin
                hit_idx = BW'(b);
            end
        end
    end

    assign hit      = |cand;
    assign hit_pos  = {word_reg, hit_idx};
    assign pos1     = LW'(hit_pos) + LW'(1);
    assign ss_next  = (pos1 == LW'(count_reg)) ? '0 : CW'(pos1);
    assign rel_ok   = (cin_reg >= CLW'(bca_pkg::FIRST_FREE))
                    && (32'(cin_reg) < 32'(count_reg));
    assign cin_word = AW'(cin_reg >> BW);
    assign end_word = AW'((hi_reg - NW'(1)) >> BW);
    assign out_free = !out_valid_reg || m_tready;

    always_comb begin
        ram_we    = cmd.clear_write || cmd.alloc_commit || cmd.rel_write;
        ram_re    = cmd.scan_read || cmd.rel_read;
        ram_raddr = cmd.rel_read ? cin_word : word_reg;
        ram_waddr = cmd.rel_write ? cin_word : word_reg;
        if (cmd.clear_write) begin
            ram_wdata = (word_reg == '0) ? bca_pkg::FIRST_WORD : bca_pkg::FULL_WORD;
        end else if (cmd.alloc_commit) begin
            ram_wdata = ram_rdata & ~(WW'(1) << hit_idx);
        end else begin
            ram_wdata = ram_rdata | (WW'(1) << cin_reg[BW-1:0]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= NW'(COUNT_RESET);
            ss_reg        <= CW'(bca_pkg::FIRST_FREE);
            fresh_reg     <= 1'b1;
            word_reg      <= '0;
            phase_b_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                count_reg <= count_cfg;
            end
            if (cmd.item_load) begin
                word_reg    <= AW'(start_pos >> BW);
                phase_b_reg <= 1'b0;
                if (bca_pkg::opcode_t'(s_tuser) == bca_pkg::OP_ALLOC) begin
                    fresh_reg <= 1'b0;
                end
            end
            if (cmd.clear_start) begin
                word_reg  <= '0;
                ss_reg    <= CW'(bca_pkg::FIRST_FREE);
                fresh_reg <= 1'b1;
            end
            if (cmd.clear_write || cmd.scan_next) begin
                word_reg <= word_reg + AW'(1);
            end
            if (cmd.phase_b) begin
                word_reg    <= '0;
                phase_b_reg <= 1'b1;
            end
            if (cmd.alloc_commit) begin
                ss_reg <= ss_next;
            end
            if (cmd.out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.item_load) begin
            op_reg    <= bca_pkg::opcode_t'(s_tuser);
            cin_reg   <= s_tdata[CLW-1:0];
            lo_reg    <= start_pos;
            hi_reg    <= count_reg;
            start_reg <= start_pos;
        end
        if (cmd.phase_b) begin
            lo_reg <= '0;
            hi_reg <= start_reg;
        end
        if (cmd.res_set) begin
            res_status_reg  <= cmd.res_status;
            res_cluster_reg <= cmd.res_alloc ? CLW'(hit_pos) : '0;
        end
        if (cmd.out_load) begin
            out_cluster_reg   <= res_cluster_reg;
            out_status_reg    <= res_status_reg;
            out_formatted_reg <= fresh_reg;
        end
    end

    always_comb begin
        stat.op         = op_reg;
        stat.rel_ok     = rel_ok;
        stat.hit        = hit;
        stat.word_last  = (word_reg == end_word);
        stat.in_phase_b = phase_b_reg;
        stat.b_empty    = (start_reg == '0);
        stat.clear_last = (word_reg == AW'(DEPTH - 1));
        stat.out_free   = out_free;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(bca_pkg::TDATA_W - CLW - 1){1'b0}}, out_formatted_reg, out_cluster_reg};
    assign m_tuser  = out_status_reg;

`ifndef SYNTHESIS
    a_commit_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.alloc_commit |-> hit)
        else $error("allocation committed without a free cluster in range");

    a_release_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.rel_write |-> rel_ok)
        else $error("release written outside the accepted range");

    a_pointer_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.alloc_commit |=> (LW'(ss_reg) < LW'(count_reg)))
        else $error("search pointer left beyond the cluster count");

    a_out_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |-> !cmd.out_load)
        else $error("result loaded over a word not yet taken");
`endif

endmodule

### rtl/core/bca_ctrl.sv
`timescale 1ns / 1ps

module bca_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  bca_pkg::dp_stat_t stat,
    output bca_pkg::dp_cmd_t  cmd
);

    bca_pkg::state_t state_reg;
    bca_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= bca_pkg::S_INIT;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        s_tready   = 1'b0;
        unique case (state_reg)
            bca_pkg::S_INIT: begin
                cmd.clear_write = 1'b1;
                if (stat.clear_last) begin
                    state_next = bca_pkg::S_IDLE;
                end
            end
            bca_pkg::S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.item_load = 1'b1;
                    state_next    = bca_pkg::S_DECODE;
                end
            end
            bca_pkg::S_DECODE: begin
                unique case (stat.op)
                    bca_pkg::OP_ALLOC: begin
                        state_next = bca_pkg::S_SCAN_RD;
                    end
                    bca_pkg::OP_RELEASE: begin
                        if (stat.rel_ok) begin
                            state_next = bca_pkg::S_REL_RD;
                        end else begin
                            cmd.res_set    = 1'b1;
                            cmd.res_status = bca_pkg::STS_REJECT;
                            state_next     = bca_pkg::S_OUT;
                        end
                    end
                    bca_pkg::OP_FORMAT: begin
                        cmd.clear_start = 1'b1;
                        state_next      = bca_pkg::S_CLEAR;
                    end
                    default: begin
                        cmd.res_set    = 1'b1;
                        cmd.res_status = bca_pkg::STS_OK;
                        state_next     = bca_pkg::S_OUT;
                    end
                endcase
            end
            bca_pkg::S_CLEAR: begin
                cmd.clear_write = 1'b1;
                if (stat.clear_last) begin
                    cmd.res_set    = 1'b1;
                    cmd.res_status = bca_pkg::STS_OK;
                    state_next     = bca_pkg::S_OUT;
                end
            end
            bca_pkg::S_SCAN_RD: begin
                cmd.scan_read = 1'b1;
                state_next    = bca_pkg::S_SCAN_CHK;
            end
            bca_pkg::S_SCAN_CHK: begin
                if (stat.hit) begin
                    cmd.alloc_commit = 1'b1;
                    cmd.res_set      = 1'b1;
                    cmd.res_alloc    = 1'b1;
                    cmd.res_status   = bca_pkg::STS_OK;
                    state_next       = bca_pkg::S_OUT;
                end else if (!stat.word_last) begin
                    cmd.scan_next = 1'b1;
                    state_next    = bca_pkg::S_SCAN_RD;
                end else if (!stat.in_phase_b && !stat.b_empty) begin
                    cmd.phase_b = 1'b1;
                    state_next  = bca_pkg::S_SCAN_RD;
                end else begin
                    cmd.res_set    = 1'b1;
                    cmd.res_status = bca_pkg::STS_FULL;
                    state_next     = bca_pkg::S_OUT;
                end
            end
            bca_pkg::S_REL_RD: begin
                cmd.rel_read = 1'b1;
                state_next   = bca_pkg::S_REL_WR;
            end
            bca_pkg::S_REL_WR: begin
                cmd.rel_write  = 1'b1;
                cmd.res_set    = 1'b1;
                cmd.res_status = bca_pkg::STS_OK;
                state_next     = bca_pkg::S_OUT;
            end
            bca_pkg::S_OUT: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = bca_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = bca_pkg::S_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_accept_decode: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == bca_pkg::S_DECODE))
        else $error("accepted word not decoded in the following cycle");

    a_result_once: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |=> (state_reg == bca_pkg::S_IDLE) && !cmd.out_load)
        else $error("result loaded twice for one word");

    a_scan_after_read: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == bca_pkg::S_SCAN_CHK) |-> $past(cmd.scan_read))
        else $error("bitmap word checked without a preceding read");
`endif

endmodule

### rtl/core/bitmap_cluster_allocator_core.sv
`timescale 1ns / 1ps
// Sequence: an allocate passes decode, then a read and a check state per 8-cluster bitmap word
//   scanned, then the output state; a release passes decode, read, write and output; a rejected
//   release or unused opcode goes from decode to output; a format clears every bitmap word first.
// Throughput: one word at a time; the next word is taken the cycle after its result is loaded.
//   The scan reads one bitmap word at a time through the single read port of the bitmap memory.
// Reset: synchronous active-low aresetn, then a clearing pass formats all ceil(MAX_CLUSTERS / 8)
//   bitmap words (512 at the default) with s_tready low; cfg writes are taken out of reset.

module bitmap_cluster_allocator_core #(
    parameter int MAX_CLUSTERS = 4096
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [bca_pkg::CFG_W-1:0]     cfg_data,   // cluster_count
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [bca_pkg::TDATA_W-1:0]   s_tdata,    // [11:0] cluster_in
    input  logic [bca_pkg::OP_W-1:0]      s_tuser,    // [1:0] opcode
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [bca_pkg::TDATA_W-1:0]   m_tdata,    // [11:0] cluster_out, [12] formatted
    output logic [bca_pkg::STATUS_W-1:0]  m_tuser     // [1:0] status
);

    bca_pkg::dp_cmd_t  cmd;
    bca_pkg::dp_stat_t stat;

    assign cfg_ready = aresetn;

    bca_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    bca_datapath #(
        .MAX_CLUSTERS (MAX_CLUSTERS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule
